>>> rtl/bmpd_pkg.sv
// Package: shared constants and types for the BMP pixel-data decoder.
package bmpd_pkg;

  localparam int unsigned MaxDim = 1024;
  localparam int unsigned DimW   = $clog2(MaxDim + 1);
  localparam int unsigned OutW   = $clog2(MaxDim);
  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    PhCount  = 3'd0,
    PhRunVal = 3'd1,
    PhEscape = 3'd2,
    PhDx     = 3'd3,
    PhDy     = 3'd4,
    PhLit    = 3'd5,
    PhFill   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    Depth4  = 2'd0,
    Depth8  = 2'd1,
    Depth24 = 2'd2
  } depth_e;

  typedef enum logic [2:0] {
    RegWidth  = 3'd0,
    RegHeight = 3'd1,
    RegDepth  = 3'd2,
    RegRle    = 3'd3,
    RegTopDn  = 3'd4
  } reg_e;

  // Pixel job handed from the byte parser to the span generator.
  typedef struct packed {
    logic            restart;  // clear column/row before the job
    logic            rle;      // run-style placement with row wrap
    logic            drop;     // only update position, emit nothing
    logic [1:0]      raw_n;    // raw mode: pixels in job (0..2)
    logic [7:0]      count;    // rle run length
    logic [23:0]     val0;
    logic [3:0]      val1;
    logic            raw_eol;  // raw: row ends after this byte
    logic            eob;      // rle end of bitmap
    logic            newline;  // rle end of line
    logic            delta;    // rle delta: dx in count, dy in val0[7:0]
  } job_t;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            top_down;
  } geom_t;

endpackage

>>> rtl/bmpd_front.sv
// Byte parser: RLE8 command decode, raw byte/pixel assembly and row padding.
module bmpd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      first_of_image_i,
  input  logic [bmpd_pkg::DimW-1:0] width_i,
  input  logic [1:0]                depth_i,
  input  logic                      rle_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output bmpd_pkg::job_t            job_o
);

  bmpd_pkg::phase_e    phase_q, phase_d;
  logic [7:0]          lit_q, lit_d;
  logic                pad_q, pad_d;
  logic [7:0]          dx_q, dx_d;
  logic [15:0]         held_q, held_d;
  logic [1:0]          cbi_q, cbi_d;
  logic [11:0]         rbc_q, rbc_d;
  logic [bmpd_pkg::DimW-1:0] col_q, col_d;   // raw-mode column shadow
  logic [7:0]          run_q, run_d;
  logic                go;
  logic [bmpd_pkg::DimW-1:0] w;
  logic [16:0]         bits;
  logic [11:0]         bpr;
  logic [bmpd_pkg::DimW-1:0] col_s;
  logic [1:0]          cbi_s;
  logic [15:0]         held_s;
  logic [11:0]         rbc_s;
  bmpd_pkg::phase_e    phase_s;

  assign in_ready_o  = job_ready_i;
  assign go          = in_valid_i && job_ready_i;
  assign job_valid_o = in_valid_i;

  always_comb begin
    w = width_i;
    if (w < bmpd_pkg::DimW'(8)) w = bmpd_pkg::DimW'(8);
    if (w > bmpd_pkg::DimW'(bmpd_pkg::MaxDim)) w = bmpd_pkg::DimW'(bmpd_pkg::MaxDim);
    unique case (depth_i)
      bmpd_pkg::Depth4:  bits = {6'd0, w} << 2;
      bmpd_pkg::Depth24: bits = ({6'd0, w} << 4) + ({6'd0, w} << 3);
      default:           bits = {6'd0, w} << 3;
    endcase
    bpr = 12'(((bits + 17'd31) >> 5) << 2);
  end

  always_comb begin
    job_o   = '0;
    job_o.restart = first_of_image_i;
    phase_s = first_of_image_i ? bmpd_pkg::PhCount : phase_q;
    col_s   = first_of_image_i ? '0 : col_q;
    cbi_s   = first_of_image_i ? '0 : cbi_q;
    held_s  = first_of_image_i ? '0 : held_q;
    rbc_s   = first_of_image_i ? '0 : rbc_q;
    phase_d = phase_s;
    lit_d   = first_of_image_i ? '0 : lit_q;
    pad_d   = first_of_image_i ? 1'b0 : pad_q;
    dx_d    = dx_q;
    run_d   = run_q;
    held_d  = held_s;
    cbi_d   = cbi_s;
    rbc_d   = rbc_s;
    col_d   = col_s;
    job_o.rle  = rle_i;
    job_o.drop = 1'b1;
    if (rle_i) begin
      unique case (phase_s)
        bmpd_pkg::PhCount: begin
          if (data_byte_i == 8'd0) phase_d = bmpd_pkg::PhEscape;
          else begin
            run_d = data_byte_i; phase_d = bmpd_pkg::PhRunVal;
          end
        end
        bmpd_pkg::PhRunVal: begin
          job_o.drop = 1'b0; job_o.count = run_q;
          job_o.val0 = {16'd0, data_byte_i};
          phase_d = bmpd_pkg::PhCount;
        end
        bmpd_pkg::PhEscape: begin
          phase_d = bmpd_pkg::PhCount;
          if (data_byte_i == 8'd0) job_o.newline = 1'b1;
          else if (data_byte_i == 8'd1) job_o.eob = 1'b1;
          else if (data_byte_i == 8'd2) phase_d = bmpd_pkg::PhDx;
          else begin
            lit_d = data_byte_i; pad_d = data_byte_i[0]; phase_d = bmpd_pkg::PhLit;
          end
        end
        bmpd_pkg::PhDx: begin
          dx_d = data_byte_i; phase_d = bmpd_pkg::PhDy;
        end
        bmpd_pkg::PhDy: begin
          job_o.delta = 1'b1; job_o.count = dx_q;
          job_o.val0 = {16'd0, data_byte_i};
          phase_d = bmpd_pkg::PhCount;
        end
        bmpd_pkg::PhLit: begin
          job_o.drop = 1'b0; job_o.count = 8'd1;
          job_o.val0 = {16'd0, data_byte_i};
          if (lit_d != 8'd0) lit_d = lit_d - 8'd1;
          if (lit_d == 8'd0) begin
            phase_d = pad_d ? bmpd_pkg::PhFill : bmpd_pkg::PhCount;
            pad_d = 1'b0;
          end
        end
        default: phase_d = bmpd_pkg::PhCount;
      endcase
    end else begin
      // raw mode: column shadow tracks whether pixels still fit the row
      if (col_s < w) begin
        if (depth_i == bmpd_pkg::Depth24) begin
          if (cbi_s < 2'd2) begin
            cbi_d = cbi_s + 2'd1;
            held_d = {held_s[7:0], data_byte_i};
          end else begin
            job_o.drop = 1'b0; job_o.raw_n = 2'd1;
            job_o.val0 = {data_byte_i, held_s[7:0], held_s[15:8]};
            col_d = col_s + 1'b1; cbi_d = '0; held_d = '0;
          end
        end else if (depth_i == bmpd_pkg::Depth4) begin
          job_o.drop = 1'b0;
          job_o.val0 = {20'd0, data_byte_i[7:4]};
          job_o.val1 = data_byte_i[3:0];
          if (col_s + 1'b1 < w) begin
            job_o.raw_n = 2'd2; col_d = col_s + 2'd2;
          end else begin
            job_o.raw_n = 2'd1; col_d = w;
          end
        end else begin
          job_o.drop = 1'b0; job_o.raw_n = 2'd1;
          job_o.val0 = {16'd0, data_byte_i};
          col_d = col_s + 1'b1;
        end
      end
      rbc_d = rbc_s + 12'd1;
      if (rbc_d >= bpr) begin
        rbc_d = '0; cbi_d = '0; held_d = '0; col_d = '0;
        job_o.raw_eol = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bmpd_pkg::PhCount;
      lit_q <= '0; pad_q <= 1'b0; held_q <= '0; cbi_q <= '0;
      rbc_q <= '0; col_q <= '0; dx_q <= '0; run_q <= '0;
    end else if (go) begin
      phase_q <= phase_d; lit_q <= lit_d; pad_q <= pad_d; held_q <= held_d;
      cbi_q <= cbi_d; rbc_q <= rbc_d; col_q <= col_d; dx_q <= dx_d; run_q <= run_d;
    end
  end

endmodule

>>> rtl/bmpd_queue.sv
// Two-entry job queue between parser and span generator.
module bmpd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  bmpd_pkg::job_t wr_job_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output bmpd_pkg::job_t rd_job_o
);

  bmpd_pkg::job_t mem_q [bmpd_pkg::QDepth];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign wr_ready_o = cnt_q != 2'(bmpd_pkg::QDepth);
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_job_o   = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/bmpd_back.sv
// Span generator: position tracking, row wrap, flip and output register.
module bmpd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  output logic                      job_ready_o,
  input  bmpd_pkg::job_t            job_i,
  input  bmpd_pkg::geom_t           geom_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [9:0]                column_o,
  output logic [9:0]                row_o,
  output logic [7:0]                span_length_o,
  output logic [23:0]               pixel_value_o,
  output logic                      image_done_o,
  output logic                      last_o
);

  localparam int unsigned DW = bmpd_pkg::DimW;

  logic [DW-1:0] col_q, col_d, row_q, row_d;
  logic          done_q, done_d;
  logic [7:0]    left_q, left_d;      // remaining run pixels
  logic          busy_q, busy_d;      // working on a multi-span job
  logic          sec_q, sec_d;        // raw second nibble pending
  logic          ov_q;
  logic [9:0]    oc_q, or_q;
  logic [7:0]    ol_q;
  logic [23:0]   ov_val_q;
  logic          od_q, olast_q;
  logic          space, take;
  logic [DW-1:0] w, h;
  logic          em;
  logic [DW-1:0] ecol, erow;
  logic [7:0]    elen;
  logic [23:0]   eval;
  logic          elast, fin;
  logic [DW-1:0] cs, rs;
  logic          ds;
  logic [DW-1:0] k;
  logic [DW:0]   tmp;
  logic [DW-1:0] cend;                // raw: column once the whole byte is placed
  logic          dspan;               // done flag as seen after the whole byte
  logic [21:0]   capv;                // pixels left in the image from here

  always_comb begin
    w = geom_i.width;
    if (w < DW'(8)) w = DW'(8);
    if (w > DW'(bmpd_pkg::MaxDim)) w = DW'(bmpd_pkg::MaxDim);
    h = geom_i.height;
    if (h < DW'(1)) h = DW'(1);
    if (h > DW'(bmpd_pkg::MaxDim)) h = DW'(bmpd_pkg::MaxDim);
  end

  assign space = !ov_q || out_ready_i;

  // One span per cycle while the output has space; a job retires once fin is set.
  always_comb begin
    cs = col_q; rs = row_q; ds = done_q;
    if (!busy_q && job_i.restart) begin
      cs = '0; rs = '0; ds = 1'b0;
    end
    col_d = cs; row_d = rs; done_d = ds;
    left_d = left_q; busy_d = busy_q; sec_d = sec_q;
    em = 1'b0; ecol = cs; erow = rs; elen = 8'd1; eval = job_i.val0;
    elast = 1'b0; fin = 1'b1; k = '0; tmp = '0;
    cend = cs; dspan = ds; capv = '0;
    if (job_valid_i && space && !(ds && !busy_q)) begin
      if (!job_i.rle) begin
        if (!job_i.drop) begin
          if (sec_q) begin
            eval = {20'd0, job_i.val1};
          end
          em = rs < h;
          col_d = cs + 1'b1;
          cend = cs + 1'b1;
          if (job_i.raw_n == 2'd2 && !sec_q) begin
            fin = 1'b0; sec_d = 1'b1; busy_d = 1'b1;
            cend = cs + DW'(2);
          end else begin
            sec_d = 1'b0; busy_d = 1'b0;
          end
          // byte completes the last row
          if (cend >= w && rs + 1'b1 == h) dspan = 1'b1;
        end
        if (job_i.raw_eol && rs + 1'b1 >= h) dspan = 1'b1;
        if (fin) begin
          done_d = dspan;
          if (job_i.raw_eol) begin
            col_d = '0;
            if (rs < h) row_d = rs + 1'b1;
          end
        end
        elast = fin;
      end else if (job_i.newline) begin
        col_d = '0; if (rs < h) row_d = rs + 1'b1;
      end else if (job_i.eob) begin
        done_d = 1'b1;
      end else if (job_i.delta) begin
        tmp = {1'b0, cs} + (DW+1)'(job_i.count);
        col_d = (tmp > {1'b0, w}) ? w : tmp[DW-1:0];
        tmp = {1'b0, rs} + (DW+1)'(job_i.val0[7:0]);
        row_d = (tmp > {1'b0, h}) ? h : tmp[DW-1:0];
      end else if (!job_i.drop) begin
        // run placement, one row segment per cycle while the output has space
        left_d = busy_q ? left_q : job_i.count;
        if (left_d != 8'd0 && rs < h) begin
          // run longer than what is left of the image: every span carries done
          capv = 22'(h - rs) * 22'(w) - 22'(cs);
          if (22'(left_d) > capv) dspan = 1'b1;
          if (cs >= w) begin
            cs = '0; rs = rs + 1'b1; col_d = '0; row_d = rs;
          end
          if (rs < h) begin
            k = w - cs;
            if (k > DW'(left_d)) k = DW'(left_d);
            em = 1'b1; ecol = cs; erow = rs; elen = k[7:0];
            col_d = cs + k;
            left_d = left_d - k[7:0];
            if (left_d != 8'd0) begin
              fin = 1'b0; busy_d = 1'b1;
            end
          end
        end
        if (fin) busy_d = 1'b0;
      end
      if (job_i.rle && fin && row_d >= h) done_d = 1'b1;
      if (job_i.rle) begin
        // last span of the byte: nothing more will follow
        elast = fin;
        if (!fin && col_d >= w && row_d + 1'b1 >= h) elast = 1'b1;
        if (elast && !fin) begin
          // rest of the run falls past the last row
          fin = 1'b1; busy_d = 1'b0;
          col_d = '0; row_d = h; done_d = 1'b1;
        end
      end
    end else begin
      fin = !(job_valid_i && space) ? 1'b0 : 1'b1;
      col_d = col_q; row_d = row_q; done_d = done_q;
      if (job_valid_i && space) begin
        col_d = cs; row_d = rs; done_d = ds;
      end
    end
  end

  assign take        = job_valid_i && space && fin;
  assign job_ready_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; done_q <= 1'b0; left_q <= '0;
      busy_q <= 1'b0; sec_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (job_valid_i && space) begin
        col_q <= col_d; row_q <= row_d; done_q <= done_d;
        left_q <= left_d; busy_q <= busy_d; sec_q <= sec_d;
      end
      if (space) ov_q <= job_valid_i && em;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space && job_valid_i && em) begin
      oc_q     <= ecol[9:0];
      or_q     <= geom_i.top_down ? erow[9:0] : 10'(h - 1'b1 - erow);
      ol_q     <= elen;
      ov_val_q <= eval;
      od_q     <= dspan;
      olast_q  <= elast;
    end
  end

  assign out_valid_o   = ov_q;
  assign column_o      = oc_q;
  assign row_o         = or_q;
  assign span_length_o = ol_q;
  assign pixel_value_o = ov_val_q;
  assign image_done_o  = od_q;
  assign last_o        = olast_q;

endmodule

>>> rtl/bmp_pixel_data_decoder_core.sv
// Top level of the BMP pixel-data decoder.
// Decodes BMP pixel data one byte per word into spans (column, display row,
// length, value). Raw rows (4/8/24-bit) and RLE8 are supported, set through
// the plain write port; the user must write it only while idle, the block
// does not enforce it. A byte passes the parser combinationally and sits in
// a two-entry queue; the generator then emits one span per cycle while the
// output is free. With the queue empty and the output free, the first span
// of a byte passes the queue entry and then the output register before it is
// offered. Raw 4-bit bytes give one span per pixel, an RLE8 run one span
// per row segment; all else sustains one byte per cycle. Spans pass through
// one output register; the generator stalls while it is full and unread.
module bmp_pixel_data_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_image_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  column_o,
  output logic [9:0]  row_o,
  output logic [7:0]  span_length_o,
  output logic [23:0] pixel_value_o,
  output logic        image_done_o,
  output logic        last_o
);

  logic [10:0] width_q, height_q;
  logic [1:0]  depth_q;
  logic        rle_q, top_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 11'd8; height_q <= 11'd1; depth_q <= bmpd_pkg::Depth8;
      rle_q <= 1'b0; top_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bmpd_pkg::RegWidth:  width_q  <= cfg_data_i;
        bmpd_pkg::RegHeight: height_q <= cfg_data_i;
        bmpd_pkg::RegDepth:  depth_q  <= cfg_data_i[1:0];
        bmpd_pkg::RegRle:    rle_q    <= cfg_data_i[0];
        bmpd_pkg::RegTopDn:  top_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic            fj_valid, fj_ready, bj_valid, bj_ready;
  bmpd_pkg::job_t  fj, bj;
  bmpd_pkg::geom_t geom;

  assign geom = '{width: width_q, height: height_q, top_down: top_q};

  bmpd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i, .first_of_image_i,
    .width_i(width_q), .depth_i(depth_q), .rle_i(rle_q),
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj)
  );

  bmpd_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fj_valid), .wr_ready_o(fj_ready), .wr_job_i(fj),
    .rd_valid_o(bj_valid), .rd_ready_i(bj_ready), .rd_job_o(bj)
  );

  bmpd_back u_back (
    .clk_i, .rst_ni, .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj),
    .geom_i(geom), .out_valid_o, .out_ready_i, .column_o, .row_o, .span_length_o,
    .pixel_value_o, .image_done_o, .last_o
  );

endmodule
